### rtl/qeam_pkg.sv
// Shared types and constants for the quad edge adjacency matcher.
// Used by the top level, the front part and the back part; depends on nothing.
package qeam_pkg;

    // Number of sides of a quad, and the code of its last side.
    localparam int unsigned NUM_SIDES = 4;
    localparam logic [1:0] SIDE_LAST = 2'd3;

    // State of one slot of the edge table.
    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_FULL  = 2'd1,
        SLOT_TOMB  = 2'd2
    } t_slot_state;

    // States of the table engine.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_OUT
    } t_back_state;

    // Status that the table engine reports to the rest of the block.
    typedef struct packed {
        logic clearing;
        logic idle;
    } t_back_status;

endpackage

### rtl/qeam_ifs.sv
// Handshake interfaces for the quad input channel and the edge result channel.
// Depend on no package; widths follow the parameters of the top level.
interface qeam_quad_if #(
    parameter int unsigned VERTEX_BITS = 20,
    parameter int unsigned QUAD_BITS   = 18
);
    logic                   valid;
    logic                   ready;
    logic                   new_mesh;
    logic [QUAD_BITS-1:0]   quad_id;
    logic [VERTEX_BITS-1:0] vertex_a;
    logic [VERTEX_BITS-1:0] vertex_b;
    logic [VERTEX_BITS-1:0] vertex_c;
    logic [VERTEX_BITS-1:0] vertex_d;

    modport source (output valid, new_mesh, quad_id, vertex_a, vertex_b, vertex_c, vertex_d,
                    input ready);
    modport sink (input valid, new_mesh, quad_id, vertex_a, vertex_b, vertex_c, vertex_d,
                  output ready);
endinterface

interface qeam_edge_if #(
    parameter int unsigned QUAD_BITS = 18
);
    logic                 valid;
    logic                 ready;
    logic [QUAD_BITS-1:0] own_quad;
    logic [1:0]           own_side;
    logic                 matched;
    logic [QUAD_BITS-1:0] other_quad;
    logic [1:0]           other_side;
    logic                 table_full;
    logic                 last_edge;

    modport source (output valid, own_quad, own_side, matched, other_quad, other_side,
                    table_full, last_edge, input ready);
    modport sink (input valid, own_quad, own_side, matched, other_quad, other_side,
                  table_full, last_edge, output ready);
endinterface

### rtl/quad_edge_adjacency_matcher.sv
// Quad edge adjacency matcher, top level. Each quad gives four words, one per side.
// Each edge leaves the queue and is probed against the edge table one slot at a time, a read
// then a check, through the one read port of the table; a long probe chain visits up to
// TABLE_DEPTH slots. Its result word is held until taken before the next edge is started.
// Reset, and a quad with new_mesh set, start a sweep over every slot that empties the
// table; no quad is taken during the sweep.
module quad_edge_adjacency_matcher #(
    parameter int unsigned VERTEX_BITS = 20,
    parameter int unsigned QUAD_BITS   = 18,
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qeam_quad_if.sink i_quad,
    qeam_edge_if.source o_edge
);
    import qeam_pkg::*;

    localparam int unsigned CMD_BITS = 2 * VERTEX_BITS + QUAD_BITS + 4;

    logic                w_push;
    logic [CMD_BITS-1:0] w_push_cmd;
    logic                w_full;
    logic                w_pop;
    logic                w_cmd_valid;
    logic [CMD_BITS-1:0] w_cmd;
    t_back_status        w_status;

    qeam_front #(
        .VERTEX_BITS(VERTEX_BITS),
        .QUAD_BITS  (QUAD_BITS),
        .CMD_BITS   (CMD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_status(w_status),
        .i_quad  (i_quad),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd),
        .i_full  (w_full)
    );

    qeam_queue #(
        .WIDTH(CMD_BITS)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_cmd),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_cmd_valid),
        .o_data (w_cmd)
    );

    qeam_back #(
        .VERTEX_BITS(VERTEX_BITS),
        .QUAD_BITS  (QUAD_BITS),
        .TABLE_DEPTH(TABLE_DEPTH),
        .CMD_BITS   (CMD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_pop      (w_pop),
        .o_status   (w_status),
        .o_edge     (o_edge)
    );
endmodule

### rtl/qeam_queue.sv
// Short first-in first-out queue of edge commands between front and back.
// Depends on nothing but its width parameter.
module qeam_queue #(
    parameter int unsigned WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned DEPTH = 4;

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [1:0]       r_wr;
    logic [1:0]       r_rd;
    logic [2:0]       r_cnt;

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_buf[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop && o_valid) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'((i_push && !o_full) ? 1 : 0) - 3'((i_pop && o_valid) ? 1 : 0);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_buf[r_wr] <= i_data;
        end
    end
endmodule

### rtl/qeam_front.sv
// Front part: splits a quad into its edge commands, pushed while the queue has room, before taking the next quad.
// Depends on qeam_pkg and the quad channel interface.
module qeam_front #(
    parameter int unsigned VERTEX_BITS = 20,
    parameter int unsigned QUAD_BITS   = 18,
    parameter int unsigned CMD_BITS    = 2 * VERTEX_BITS + QUAD_BITS + 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qeam_pkg::t_back_status i_status,
    qeam_quad_if.sink           i_quad,
    output logic                o_push,
    output logic [CMD_BITS-1:0] o_cmd,
    input  logic                i_full
);
    import qeam_pkg::*;

    logic                   r_busy;
    logic [1:0]             r_side;
    logic                   r_new_mesh;
    logic [QUAD_BITS-1:0]   r_quad;
    logic [VERTEX_BITS-1:0] r_v [NUM_SIDES];
    logic [VERTEX_BITS-1:0] w_p;
    logic [VERTEX_BITS-1:0] w_q;
    logic [VERTEX_BITS-1:0] w_lo;
    logic [VERTEX_BITS-1:0] w_hi;

    assign i_quad.ready = !r_busy && !i_status.clearing;

    // Sorted vertex pair of the current side forms the key.
    always_comb begin
        w_p  = r_v[r_side];
        w_q  = r_v[r_side + 2'd1];
        w_lo = (w_p < w_q) ? w_p : w_q;
        w_hi = (w_p < w_q) ? w_q : w_p;
    end

    assign o_push = r_busy && !i_full;
    assign o_cmd  = {(r_new_mesh && (r_side == 2'd0)), (r_side == SIDE_LAST), r_side,
                     r_quad, w_lo, w_hi};

    // Control of the quad register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_side <= '0;
        end else if (i_quad.valid && i_quad.ready) begin
            r_busy <= 1'b1;
            r_side <= '0;
        end else if (o_push) begin
            r_side <= r_side + 2'd1;
            if (r_side == SIDE_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quad payload.
    always_ff @(posedge i_clk) begin
        if (i_quad.valid && i_quad.ready) begin
            r_new_mesh <= i_quad.new_mesh;
            r_quad     <= i_quad.quad_id;
            r_v[0]     <= i_quad.vertex_a;
            r_v[1]     <= i_quad.vertex_b;
            r_v[2]     <= i_quad.vertex_c;
            r_v[3]     <= i_quad.vertex_d;
        end
    end
endmodule

### rtl/qeam_back.sv
// Back part: hashed edge table with linear probing, tombstones and a clearing sweep.
// Depends on qeam_pkg and the edge result interface.
module qeam_back #(
    parameter int unsigned VERTEX_BITS = 20,
    parameter int unsigned QUAD_BITS   = 18,
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned CMD_BITS    = 2 * VERTEX_BITS + QUAD_BITS + 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  logic [CMD_BITS-1:0] i_cmd,
    output logic                o_pop,
    output qeam_pkg::t_back_status o_status,
    qeam_edge_if.source         o_edge
);
    import qeam_pkg::*;

    localparam int unsigned KW  = 2 * VERTEX_BITS;
    localparam int unsigned IW  = $clog2(TABLE_DEPTH);
    localparam int unsigned CNW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned EW  = 2 + KW + QUAD_BITS + 2;
    localparam int unsigned NCH = (KW + IW - 1) / IW;

    t_back_state          r_state, n_state;
    logic [IW-1:0]        r_addr, n_addr;
    logic [IW-1:0]        r_probes, n_probes;
    logic [IW-1:0]        r_free, n_free;
    logic                 r_free_ok, n_free_ok;
    logic [CNW-1:0]       r_count, n_count;
    logic [IW-1:0]        r_clr, n_clr;
    logic                 r_pending, n_pending;

    logic                 r_last;
    logic [1:0]           r_side;
    logic [QUAD_BITS-1:0] r_quad;
    logic [KW-1:0]        r_key;

    logic [EW-1:0]        r_mem [TABLE_DEPTH];
    logic [EW-1:0]        r_rd;

    logic                 r_res_matched;
    logic [QUAD_BITS-1:0] r_res_quad;
    logic [1:0]           r_res_side;
    logic                 r_res_full;

    t_slot_state          e_state;
    logic [KW-1:0]        e_key;
    logic [QUAD_BITS-1:0] e_quad;
    logic [1:0]           e_side;
    logic                 w_hit, w_empty, w_wrap, w_done, w_free_ok, w_insert;
    logic [IW-1:0]        w_free, w_hash, w_next;
    logic                 w_we;
    logic [IW-1:0]        w_waddr;
    logic [EW-1:0]        w_wdata;

    // Fold the key into a table index, then bring it below the depth.
    function automatic logic [IW-1:0] hash_key(input logic [KW-1:0] key);
        logic [KW+IW-1:0] kx;
        logic [KW+IW-1:0] sh;
        logic [IW-1:0]    h;
        kx = {{IW{1'b0}}, key};
        h  = '0;
        for (int i = 0; i < NCH; i++) begin
            sh = kx >> (i * IW);
            h  = h ^ sh[IW-1:0];
        end
        if ({1'b0, h} >= (IW+1)'(TABLE_DEPTH)) begin
            h = h - IW'(TABLE_DEPTH);
        end
        return h;
    endfunction

    // Fields of the slot just read.
    always_comb begin
        e_state = t_slot_state'(r_rd[EW-1 -: 2]);
        e_key   = r_rd[EW-3 -: KW];
        e_quad  = r_rd[2 +: QUAD_BITS];
        e_side  = r_rd[1:0];
    end

    // Probe outcome.
    always_comb begin
        w_hit     = (r_state == S_CHECK) && (e_state == SLOT_FULL) && (e_key == r_key);
        w_empty   = (r_state == S_CHECK) && !w_hit && (e_state == SLOT_EMPTY);
        w_wrap    = (r_state == S_CHECK) && !w_hit && (e_state != SLOT_EMPTY)
                    && (r_probes == IW'(TABLE_DEPTH - 1));
        w_done    = w_empty || w_wrap;
        w_free_ok = r_free_ok || w_empty || (e_state == SLOT_TOMB);
        w_free    = r_free_ok ? r_free : r_addr;
        w_insert  = w_done && w_free_ok && (r_count < CNW'(TABLE_DEPTH));
        w_hash    = hash_key(i_cmd[KW-1:0]);
        w_next    = (r_addr == IW'(TABLE_DEPTH - 1)) ? '0 : r_addr + IW'(1);
    end

    // Next state and counters.
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_probes  = r_probes;
        n_free    = r_free;
        n_free_ok = r_free_ok;
        n_count   = r_count;
        n_clr     = r_clr;
        n_pending = r_pending;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + IW'(1);
                if (r_clr == IW'(TABLE_DEPTH - 1)) begin
                    n_clr   = '0;
                    n_count = '0;
                    n_state = r_pending ? S_READ : S_IDLE;
                    n_pending = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_addr    = w_hash;
                    n_probes  = '0;
                    n_free_ok = 1'b0;
                    if (i_cmd[CMD_BITS-1]) begin
                        n_state   = S_CLEAR;
                        n_pending = 1'b1;
                        n_clr     = '0;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_hit) begin
                    n_count = r_count - CNW'(1);
                    n_state = S_OUT;
                end else if (w_done) begin
                    if (w_insert) begin
                        n_count = r_count + CNW'(1);
                    end
                    n_state = S_OUT;
                end else begin
                    if (!r_free_ok && (e_state == SLOT_TOMB)) begin
                        n_free_ok = 1'b1;
                        n_free    = r_addr;
                    end
                    n_probes = r_probes + IW'(1);
                    n_addr   = w_next;
                    n_state  = S_READ;
                end
            end
            S_OUT: begin
                if (o_edge.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table writes, handshake and status.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = {SLOT_EMPTY, {(EW-2){1'b0}}};
        end else if (w_hit) begin
            w_we    = 1'b1;
            w_wdata = {SLOT_TOMB, {(EW-2){1'b0}}};
        end else if (w_insert) begin
            w_we    = 1'b1;
            w_waddr = w_free;
            w_wdata = {SLOT_FULL, r_key, r_quad, r_side};
        end
        o_pop             = (r_state == S_IDLE) && i_cmd_valid;
        o_edge.valid      = (r_state == S_OUT);
        o_status.clearing = (r_state == S_CLEAR);
        o_status.idle     = (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_probes  <= '0;
            r_free    <= '0;
            r_free_ok <= 1'b0;
            r_count   <= '0;
            r_clr     <= '0;
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_probes  <= n_probes;
            r_free    <= n_free;
            r_free_ok <= n_free_ok;
            r_count   <= n_count;
            r_clr     <= n_clr;
            r_pending <= n_pending;
        end
    end

    // Command payload, latched when taken from the queue.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_last      <= i_cmd[CMD_BITS-2];
            r_side      <= i_cmd[CMD_BITS-3 -: 2];
            r_quad      <= i_cmd[KW +: QUAD_BITS];
            r_key       <= i_cmd[KW-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_res_matched <= 1'b1;
            r_res_quad    <= e_quad;
            r_res_side    <= e_side;
            r_res_full    <= 1'b0;
        end else if (w_done) begin
            r_res_matched <= 1'b0;
            r_res_quad    <= '0;
            r_res_side    <= '0;
            r_res_full    <= !w_insert;
        end
    end

    // Edge table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_addr];
    end

    assign o_edge.own_quad   = r_quad;
    assign o_edge.own_side   = r_side;
    assign o_edge.matched    = r_res_matched;
    assign o_edge.other_quad = r_res_quad;
    assign o_edge.other_side = r_res_side;
    assign o_edge.table_full = r_res_full;
    assign o_edge.last_edge  = r_last;

    // The entry count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A hit and an insert never fall in the same cycle.
    a_hit_xor_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_hit && w_insert))
        else $error("hit and insert together");

    // A delivered word is followed by an idle engine.
    a_out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_edge.valid && o_edge.ready) |=> (r_state == S_IDLE))
        else $error("engine not idle after delivery");

    // A clear request is served by a sweep before any probe.
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd[CMD_BITS-1]) |=> (r_state == S_CLEAR))
        else $error("clear request not swept");
endmodule

### test/quad_edge_adjacency_matcher_test.sv
// Self-checking bench for the quad edge adjacency matcher: random and directed
// quads, predicted edge pairings compared word by word. Depends on rtl/qeam_ifs.sv and the top level.
module quad_edge_adjacency_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VB = 20;
    localparam int unsigned QB = 18;
    localparam int unsigned DEPTH = 1024;

    typedef struct packed {
        logic          new_mesh;
        logic [QB-1:0] quad_id;
        logic [VB-1:0] va;
        logic [VB-1:0] vb;
        logic [VB-1:0] vc;
        logic [VB-1:0] vd;
    } t_quad;

    typedef struct packed {
        logic [QB-1:0] own_quad;
        logic [1:0]    own_side;
        logic          matched;
        logic [QB-1:0] other_quad;
        logic [1:0]    other_side;
        logic          table_full;
        logic          last_edge;
    } t_edge_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic failed = 1'b0;
    logic no_idle = 1'b0;

    qeam_quad_if #(.VERTEX_BITS(VB), .QUAD_BITS(QB)) quad_ch ();
    qeam_edge_if #(.QUAD_BITS(QB)) edge_ch ();

    quad_edge_adjacency_matcher #(.VERTEX_BITS(VB), .QUAD_BITS(QB), .TABLE_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_quad(quad_ch.sink),
        .o_edge(edge_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // Predicted edge table: open store of keys with owning quad and side.
    logic [2*VB-1:0] held_key [DEPTH];
    logic [QB-1:0]   held_quad [DEPTH];
    logic [1:0]      held_side [DEPTH];
    logic            held_valid [DEPTH];
    int unsigned     held_count;

    t_quad      pending_quads[$];
    t_edge_word expected_edges[$];

    task automatic clear_edge_table();
        for (int i = 0; i < DEPTH; i++) held_valid[i] = 1'b0;
        held_count = 0;
    endtask

    // Pair every edge of an accepted quad against the predicted table.
    task automatic predict_pairings(input t_quad q);
        logic [VB-1:0] v[4];
        logic [VB-1:0] p;
        logic [VB-1:0] r;
        logic [2*VB-1:0] k;
        int hit;
        int free_at;
        t_edge_word w;
        if (q.new_mesh) clear_edge_table();
        v[0] = q.va; v[1] = q.vb; v[2] = q.vc; v[3] = q.vd;
        for (int s = 0; s < 4; s++) begin
            p = v[s];
            r = v[(s + 1) % 4];
            k = (p < r) ? {p, r} : {r, p};
            hit = -1;
            free_at = -1;
            for (int i = 0; i < DEPTH; i++) begin
                if (held_valid[i]) begin
                    if (hit < 0 && held_key[i] == k) hit = i;
                end else if (free_at < 0) begin
                    free_at = i;
                end
            end
            w = '0;
            w.own_quad = q.quad_id;
            w.own_side = 2'(s);
            w.last_edge = (s == 3);
            if (hit >= 0) begin
                w.matched = 1'b1;
                w.other_quad = held_quad[hit];
                w.other_side = held_side[hit];
                held_valid[hit] = 1'b0;
                held_count--;
            end else if (free_at >= 0) begin
                held_valid[free_at] = 1'b1;
                held_key[free_at] = k;
                held_quad[free_at] = q.quad_id;
                held_side[free_at] = 2'(s);
                held_count++;
            end else begin
                w.table_full = 1'b1;
            end
            expected_edges.push_back(w);
        end
    endtask

    // Remembers whether the word on the quad channel was taken at the last rising edge.
    logic quad_taken = 1'b0;
    always @(posedge i_clk) begin
        quad_taken <= quad_ch.valid && quad_ch.ready;
    end

    // Quad driver with random idle bursts.
    int quad_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            quad_ch.valid <= 1'b0;
        end else if (quad_ch.valid && !quad_taken) begin
            // hold the word until taken
        end else if (quad_gap > 0) begin
            quad_gap <= quad_gap - 1;
            quad_ch.valid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            quad_gap <= $urandom_range(1, 16) - 1;
            quad_ch.valid <= 1'b0;
        end else if (pending_quads.size() > 0) begin
            t_quad q;
            q = pending_quads.pop_front();
            quad_ch.valid <= 1'b1;
            quad_ch.new_mesh <= q.new_mesh;
            quad_ch.quad_id <= q.quad_id;
            quad_ch.vertex_a <= q.va;
            quad_ch.vertex_b <= q.vb;
            quad_ch.vertex_c <= q.vc;
            quad_ch.vertex_d <= q.vd;
        end else begin
            quad_ch.valid <= 1'b0;
        end
    end

    // Result receiver stalls in random bursts.
    int edge_stall = 0;
    always @(negedge i_clk) begin
        if (edge_stall > 0) begin
            edge_stall <= edge_stall - 1;
            edge_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            edge_stall <= $urandom_range(1, 16) - 1;
            edge_ch.ready <= 1'b0;
        end else begin
            edge_ch.ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted quad, compare each accepted word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (quad_ch.valid && quad_ch.ready) begin
                predict_pairings({quad_ch.new_mesh, quad_ch.quad_id, quad_ch.vertex_a,
                                  quad_ch.vertex_b, quad_ch.vertex_c, quad_ch.vertex_d});
            end
            if (edge_ch.valid && edge_ch.ready) begin
                t_edge_word got;
                t_edge_word want;
                got = {edge_ch.own_quad, edge_ch.own_side, edge_ch.matched, edge_ch.other_quad,
                       edge_ch.other_side, edge_ch.table_full, edge_ch.last_edge};
                if (expected_edges.size() == 0) begin
                    $display("%0t: unexpected edge word %h", $realtime, got);
                    failed <= 1'b1;
                end else begin
                    want = expected_edges.pop_front();
                    if (got !== want) begin
                        $display("%0t: edge word mismatch: expected %h actual %h",
                                 $realtime, want, got);
                        failed <= 1'b1;
                    end
                end
            end
        end
    end

    function automatic t_quad rand_quad(input int unsigned span);
        t_quad q;
        q.new_mesh = ($urandom_range(0, 59) == 0);
        q.quad_id = QB'($urandom());
        q.va = VB'($urandom_range(0, span));
        q.vb = VB'($urandom_range(0, span));
        q.vc = VB'($urandom_range(0, span));
        q.vd = VB'($urandom_range(0, span));
        if ($urandom_range(0, 9) == 0) begin
            q.va = VB'($urandom()); q.vb = VB'($urandom());
            q.vc = VB'($urandom()); q.vd = VB'($urandom());
        end
        return q;
    endfunction

    // Stimulus: directed cases, random small-vertex meshes, then a flood that fills the table.
    initial begin
        t_quad q;
        quad_ch.valid = 1'b0;
        quad_ch.new_mesh = 1'b0;
        quad_ch.quad_id = '0;
        quad_ch.vertex_a = '0;
        quad_ch.vertex_b = '0;
        quad_ch.vertex_c = '0;
        quad_ch.vertex_d = '0;
        edge_ch.ready = 1'b0;
        clear_edge_table();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Shared edges in both orientations, third quad on one edge, extremes.
        pending_quads.push_back({1'b0, 18'd0, 20'd0, 20'd1, 20'd2, 20'd3});
        pending_quads.push_back({1'b0, 18'd1, 20'd1, 20'd0, 20'd5, 20'd6});
        pending_quads.push_back({1'b0, 18'd2, 20'd0, 20'd1, 20'd7, 20'd8});
        pending_quads.push_back({1'b0, 18'h3ffff, 20'hfffff, 20'hfffff, 20'h0, 20'hfffff});
        pending_quads.push_back({1'b0, 18'h2aaaa, 20'h55555, 20'haaaaa, 20'h55555, 20'haaaaa});
        pending_quads.push_back({1'b0, 18'h15555, 20'd9, 20'd9, 20'd9, 20'd9});
        pending_quads.push_back({1'b1, 18'd7, 20'd2, 20'd3, 20'd0, 20'd1});
        pending_quads.push_back({1'b0, 18'd8, 20'd3, 20'd2, 20'd11, 20'd12});

        // Random small-vertex meshes, so that edges are often shared.
        for (int n = 0; n < 120; n++) pending_quads.push_back(rand_quad(40));

        // Fill past capacity with distinct edges, then run without idling.
        wait (pending_quads.size() == 0 && expected_edges.size() == 0);
        for (int n = 0; n < 270; n++) begin
            q = '0;
            q.new_mesh = (n == 0);
            q.quad_id = QB'(n);
            q.va = VB'(4 * n + 1000); q.vb = VB'(4 * n + 1001);
            q.vc = VB'(4 * n + 1002); q.vd = VB'(4 * n + 1003);
            if (n >= 258) q = rand_quad(40);
            pending_quads.push_back(q);
        end
        wait (pending_quads.size() < 20);
        no_idle = 1'b1;
        wait (pending_quads.size() == 0 && !quad_ch.valid && expected_edges.size() == 0);
        repeat (50) @(posedge i_clk);
        if (!failed && expected_edges.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### quad_edge_adjacency_matcher.f
rtl/qeam_pkg.sv
rtl/qeam_ifs.sv
rtl/qeam_queue.sv
rtl/qeam_front.sv
rtl/qeam_back.sv
rtl/quad_edge_adjacency_matcher.sv
test/quad_edge_adjacency_matcher_test.sv
